// ===== rtl/assert_macros.svh =====
// Assertion macros used by the camera follow RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/ecf_pkg.sv =====
// Package with the shared types and constants of the camera follow block.
`timescale 1ns / 1ps
package ecf_pkg;
  localparam int unsigned FracBits = 8;
  localparam int unsigned CoordW = 32;
  localparam logic [31:0] OnePx = 32'd1 << FracBits;

  localparam logic [1:0] CmdTick = 2'd0;
  localparam logic [1:0] CmdSet = 2'd1;
  localparam logic [1:0] CmdMove = 2'd2;
  localparam logic [1:0] CmdClick = 2'd3;

  localparam logic [1:0] ModeOff = 2'd0;
  localparam logic [1:0] ModeKey = 2'd1;
  localparam logic [1:0] ModeMouse = 2'd2;
  // Unused mode code; it behaves as tracking off.
  localparam logic [1:0] ModeSpare = 2'd3;

  localparam logic [1:0] RegMode = 2'd0;
  localparam logic [1:0] RegWidth = 2'd1;
  localparam logic [1:0] RegHeight = 2'd2;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OpNone,
    OpApply,   // apply the command, key nudge included
    OpSquare,  // register dx*dx, dy*dy
    OpSqrtInit,
    OpSqrtStep,
    OpVel,     // velocity = max(dist/60, one pixel)
    OpDivInit, // step divisions by the length
    OpDivStep,
    OpUpdate
  } op_e;

  typedef struct packed {
    op_e op;
    logic [1:0] div_sel;  // 1 x step, 2 y step
  } ecf_cmd_t;

  typedef struct packed {
    logic pending;
    logic near;       // length at most one pixel
    logic sqrt_done;
    logic div_done;
  } ecf_stat_t;
endpackage

// ===== rtl/ecf_datapath.sv =====
// Datapath of the camera follow block: state registers, root and divider.
`timescale 1ns / 1ps
module ecf_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ecf_pkg::ecf_cmd_t    cmd_i,
  input  logic [1:0]           command_i,
  input  logic signed [31:0]   coord_x_i,
  input  logic signed [31:0]   coord_y_i,
  input  logic                 centred_i,
  input  logic [3:0]           keys_i,
  input  logic [1:0]           mode_i,
  input  logic [15:0]          width_i,
  input  logic [15:0]          height_i,
  output ecf_pkg::ecf_stat_t   stat_o,
  output logic signed [31:0]   pos_x_o,
  output logic signed [31:0]   pos_y_o
);
  logic [31:0] px_q, py_q, tx_q, ty_q;
  logic        pend_q;
  logic [31:0] dx_q, dy_q;       // magnitudes, saturated
  logic        sx_q, sy_q;
  logic [62:0] sqx_q, sqy_q;
  logic [63:0] rem_q, root_q, bit_q;
  logic [31:0] dist_q, vel_q;
  logic [63:0] num_q;            // dividend shifting out
  logic [32:0] drem_q;
  logic [31:0] quo_q;
  logic [31:0] den_q;
  logic [5:0]  cnt_q;
  logic [31:0] stx_q, sty_q;

  logic [31:0] hw, hh, cx, cy, nx, ny;
  logic [32:0] sdx, sdy;
  logic [31:0] mx, my;
  logic [63:0] rb;
  logic [33:0] dtrial;
  logic [32:0] dsh;
  logic [63:0] mxx, myy;
  logic [63:0] vprod;

  assign hw = ({16'd0, width_i} << ecf_pkg::FracBits) >> 1;
  assign hh = ({16'd0, height_i} << ecf_pkg::FracBits) >> 1;

  always_comb begin
    cx = centred_i ? coord_x_i - hw : coord_x_i;
    cy = centred_i ? coord_y_i - hh : coord_y_i;
    nx = px_q + (keys_i[2] ? ecf_pkg::OnePx : 32'd0) - (keys_i[3] ? ecf_pkg::OnePx : 32'd0);
    ny = py_q + (keys_i[0] ? ecf_pkg::OnePx : 32'd0) - (keys_i[1] ? ecf_pkg::OnePx : 32'd0);
    sdx = {tx_q[31], tx_q} - {px_q[31], px_q};
    sdy = {ty_q[31], ty_q} - {py_q[31], py_q};
    mx = sdx[32] ? ((sdx < 33'h1_8000_0001) ? 32'h7FFF_FFFF : 32'(-sdx))
                 : ((sdx > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : sdx[31:0]);
    my = sdy[32] ? ((sdy < 33'h1_8000_0001) ? 32'h7FFF_FFFF : 32'(-sdy))
                 : ((sdy > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : sdy[31:0]);
    mxx = mx * mx;
    myy = my * my;
    rb = root_q + bit_q;
    dsh = {drem_q[31:0], num_q[63]};
    dtrial = {1'b0, dsh} - {2'b0, den_q};
    // Division by 60 as a multiply by the rounded-up reciprocal of 60 scaled
    // by 2^37; this is exact for every 32-bit length.
    vprod = dist_q * 32'h8888_8889;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0; py_q <= '0; tx_q <= '0; ty_q <= '0; pend_q <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        ecf_pkg::OpApply: begin
          unique case (command_i)
            ecf_pkg::CmdSet: begin
              px_q <= cx; py_q <= cy; tx_q <= cx; ty_q <= cy; pend_q <= 1'b1;
            end
            ecf_pkg::CmdMove: begin
              tx_q <= cx; ty_q <= cy; pend_q <= 1'b1;
            end
            ecf_pkg::CmdClick: begin
              if (mode_i == ecf_pkg::ModeMouse) begin
                tx_q <= px_q + coord_x_i - hw;
                ty_q <= py_q + coord_y_i - hh;
                pend_q <= 1'b1;
              end
            end
            default: begin
              if (mode_i == ecf_pkg::ModeKey && keys_i != 4'd0) begin
                px_q <= nx; py_q <= ny; tx_q <= nx; ty_q <= ny; pend_q <= 1'b1;
              end
            end
          endcase
        end
        ecf_pkg::OpUpdate: begin
          if (dist_q <= ecf_pkg::OnePx) begin
            px_q <= tx_q; py_q <= ty_q; pend_q <= 1'b0;
          end else begin
            px_q <= px_q + (sx_q ? -stx_q : stx_q);
            py_q <= py_q + (sy_q ? -sty_q : sty_q);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      ecf_pkg::OpSquare: begin
        dx_q <= mx; dy_q <= my; sx_q <= sdx[32]; sy_q <= sdy[32];
        sqx_q <= mxx[62:0]; sqy_q <= myy[62:0];
      end
      ecf_pkg::OpSqrtInit: begin
        rem_q <= {1'b0, sqx_q} + {1'b0, sqy_q};
        root_q <= '0; bit_q <= 64'h4000_0000_0000_0000;
      end
      ecf_pkg::OpSqrtStep: begin
        if (rem_q >= rb) begin
          rem_q <= rem_q - rb; root_q <= (root_q >> 1) + bit_q;
        end else root_q <= root_q >> 1;
        bit_q <= bit_q >> 2;
        if (bit_q == 64'd1) dist_q <= (rem_q >= rb) ? 32'((root_q >> 1) + bit_q)
                                                   : 32'(root_q >> 1);
      end
      ecf_pkg::OpVel: begin
        vel_q <= ({5'd0, vprod[63:37]} < ecf_pkg::OnePx) ? ecf_pkg::OnePx
               : {5'd0, vprod[63:37]};
      end
      ecf_pkg::OpDivInit: begin
        drem_q <= '0; quo_q <= '0; cnt_q <= '0;
        unique case (cmd_i.div_sel)
          2'd1: begin num_q <= dx_q * vel_q; den_q <= dist_q; end
          default: begin num_q <= dy_q * vel_q; den_q <= dist_q; end
        endcase
      end
      ecf_pkg::OpDivStep: begin
        num_q <= num_q << 1;
        cnt_q <= cnt_q + 6'd1;
        if (!dtrial[33]) drem_q <= dtrial[32:0];
        else drem_q <= dsh;
        quo_q <= {quo_q[30:0], ~dtrial[33]};
        if (cnt_q == 6'd63) begin
          unique case (cmd_i.div_sel)
            2'd1: stx_q <= {quo_q[30:0], ~dtrial[33]};
            default: sty_q <= {quo_q[30:0], ~dtrial[33]};
          endcase
        end
      end
      default: ;
    endcase
  end

  assign stat_o.pending = pend_q;
  assign stat_o.near = dist_q <= ecf_pkg::OnePx;
  assign stat_o.sqrt_done = bit_q == 64'd1;
  assign stat_o.div_done = cnt_q == 6'd63;
  assign pos_x_o = px_q;
  assign pos_y_o = py_q;
endmodule

// ===== rtl/ecf_ctrl.sv =====
// Controller of the camera follow block: sequences one transaction.
`timescale 1ns / 1ps
module ecf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         command_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  ecf_pkg::ecf_stat_t stat_i,
  output ecf_pkg::ecf_cmd_t  cmd_o,
  output logic               busy_o
);
  typedef enum logic [3:0] {
    SIdle, SCheck, SSquare, SSqInit, SSqrt, SVel, SDivInit, SDiv, SDone
  } state_e;
  state_e state_q;
  logic [1:0] sel_q;
  logic is_tick_q;
  logic out_valid_q;

  assign in_ready_o = state_q == SIdle && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign busy_o = state_q != SIdle;
  assign cmd_o.div_sel = sel_q;

  always_comb begin
    unique case (state_q)
      SIdle:    cmd_o.op = (in_valid_i && in_ready_o) ? ecf_pkg::OpApply : ecf_pkg::OpNone;
      SSquare:  cmd_o.op = ecf_pkg::OpSquare;
      SSqInit:  cmd_o.op = ecf_pkg::OpSqrtInit;
      SSqrt:    cmd_o.op = ecf_pkg::OpSqrtStep;
      SVel:     cmd_o.op = ecf_pkg::OpVel;
      SDivInit: cmd_o.op = ecf_pkg::OpDivInit;
      SDiv:     cmd_o.op = ecf_pkg::OpDivStep;
      SDone:    cmd_o.op = ecf_pkg::OpUpdate;
      default:  cmd_o.op = ecf_pkg::OpNone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; sel_q <= 2'd0; is_tick_q <= 1'b0; out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        SIdle: if (in_valid_i && in_ready_o) begin
          is_tick_q <= command_i == ecf_pkg::CmdTick;
          state_q <= SCheck;
        end
        SCheck: begin
          if (is_tick_q && stat_i.pending) state_q <= SSquare;
          else begin out_valid_q <= 1'b1; state_q <= SIdle; end
        end
        SSquare: state_q <= SSqInit;
        SSqInit: state_q <= SSqrt;
        SSqrt: if (stat_i.sqrt_done) state_q <= SVel;
        // The length is registered by now, so the snap decision is taken here.
        SVel: begin
          sel_q <= 2'd1;
          state_q <= stat_i.near ? SDone : SDivInit;
        end
        SDivInit: state_q <= SDiv;
        SDiv: if (stat_i.div_done) begin
          if (sel_q == 2'd2) state_q <= SDone;
          else begin sel_q <= sel_q + 2'd1; state_q <= SDivInit; end
        end
        SDone: begin out_valid_q <= 1'b1; state_q <= SIdle; end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

// ===== rtl/eased_camera_follow_core.sv =====
// Top level of the eased camera follow block.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// The block handles one transaction at a time and returns one result per
// transaction: the view position and whether it is still moving. A command
// that takes no step passes the check state and then raises out_valid. A tick
// with a move pending squares the vector to the target and takes a 32-step
// square root; if the length is at most one pixel the view snaps to the
// target and the result follows, otherwise the velocity is formed by a
// reciprocal multiply, and two 64-step restoring divisions (x and y step) in
// one shared divider give the step that moves the view.
// A new transaction is accepted the cycle after the result has been taken.
// Configuration writes are accepted at any time but belong between
// transactions, while nothing is in flight.
module eased_camera_follow_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         command_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic               centred_i,
  input  logic               key_up_i,
  input  logic               key_down_i,
  input  logic               key_left_i,
  input  logic               key_right_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic               moving_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  logic [1:0] mode_q;
  logic [15:0] width_q, height_q;
  ecf_pkg::ecf_cmd_t cmd;
  ecf_pkg::ecf_stat_t stat;
  logic busy;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ecf_pkg::ModeOff; width_q <= 16'd640; height_q <= 16'd480;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ecf_pkg::RegMode: mode_q <= cfg_data_i[1:0];
        ecf_pkg::RegWidth: width_q <= cfg_data_i;
        ecf_pkg::RegHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ecf_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i,
    .out_valid_o, .out_ready_i, .stat_i(stat), .cmd_o(cmd), .busy_o(busy)
  );

  ecf_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .command_i, .coord_x_i, .coord_y_i, .centred_i,
    .keys_i({key_right_i, key_left_i, key_down_i, key_up_i}),
    .mode_i(mode_q), .width_i(width_q), .height_i(height_q),
    .stat_o(stat), .pos_x_o, .pos_y_o
  );
  assign moving_o = stat.pending;

  `ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, busy, !in_ready_o)
  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && in_ready_o, busy)
  `ASSERT_IMPL(a_out_not_busy, clk_i, rst_ni, out_valid_o, !in_ready_o)
endmodule

// ===== tb/eased_camera_follow_core_tb.sv =====
// Self-checking testbench for the eased camera follow core.
`timescale 1ns / 1ps
module eased_camera_follow_core_tb;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] x;
    logic [31:0] y;
    logic        centred;
    logic        up;
    logic        down;
    logic        left;
    logic        right;
  } cam_item_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic        moving;
  } cam_view_t;

  // Tracks the camera state and the queue of positions the block must report.
  class camera_scoreboard;
    logic [1:0]  mode;
    logic [15:0] view_w;
    logic [15:0] view_h;
    logic [31:0] px, py, tx, ty;
    logic        pending;
    cam_view_t   views_due[$];
    int          mismatches;
    int          results_seen;

    function void clear();
      mode = ecf_pkg::ModeOff;
      view_w = 16'd640;
      view_h = 16'd480;
      px = '0; py = '0; tx = '0; ty = '0;
      pending = 1'b0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      if (idx == ecf_pkg::RegMode) mode = val[1:0];
      else if (idx == ecf_pkg::RegWidth) view_w = val;
      else if (idx == ecf_pkg::RegHeight) view_h = val;
    endfunction

    function logic [31:0] half_view(logic [15:0] size);
      return (32'(size) << ecf_pkg::FracBits) >> 1;
    endfunction

    function longint clamp_delta(logic [31:0] to_c, logic [31:0] from_c);
      longint d;
      d = longint'($signed(to_c)) - longint'($signed(from_c));
      if (d > 64'sd2147483647) d = 64'sd2147483647;
      if (d < -64'sd2147483647) d = -64'sd2147483647;
      return d;
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= root + bitv) begin
          v = v - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root;
    endfunction

    function logic [31:0] stride(longint d, longint unsigned vel, longint unsigned span);
      longint unsigned mag, s;
      mag = (d < 0) ? longint'(-d) : longint'(d);
      s = (mag * vel) / span;
      return (d < 0) ? (32'd0 - s[31:0]) : s[31:0];
    endfunction

    function void ease_toward_target();
      longint dx, dy;
      longint unsigned span, vel;
      dx = clamp_delta(tx, px);
      dy = clamp_delta(ty, py);
      span = root_floor(longint'(dx * dx) + longint'(dy * dy));
      if (span <= (64'd1 << ecf_pkg::FracBits)) begin
        px = tx;
        py = ty;
        pending = 1'b0;
      end else begin
        vel = span / 60;
        if (vel < (64'd1 << ecf_pkg::FracBits)) vel = 64'd1 << ecf_pkg::FracBits;
        px = px + stride(dx, vel, span);
        py = py + stride(dy, vel, span);
      end
    endfunction

    function void note_item(cam_item_t it);
      logic [31:0] cx, cy, one;
      cam_view_t v;
      one = 32'd1 << ecf_pkg::FracBits;
      cx = it.x;
      cy = it.y;
      if (it.cmd == ecf_pkg::CmdSet || it.cmd == ecf_pkg::CmdMove) begin
        if (it.centred) begin
          cx = cx - half_view(view_w);
          cy = cy - half_view(view_h);
        end
        if (it.cmd == ecf_pkg::CmdSet) begin
          px = cx;
          py = cy;
        end
        tx = cx;
        ty = cy;
        pending = 1'b1;
      end else if (it.cmd == ecf_pkg::CmdClick) begin
        if (mode == ecf_pkg::ModeMouse) begin
          tx = px + cx - half_view(view_w);
          ty = py + cy - half_view(view_h);
          pending = 1'b1;
        end
      end else begin
        if (mode == ecf_pkg::ModeKey && (it.up || it.down || it.left || it.right)) begin
          if (it.up) py = py + one;
          if (it.down) py = py - one;
          if (it.left) px = px + one;
          if (it.right) px = px - one;
          tx = px;
          ty = py;
          pending = 1'b1;
        end
        if (pending) ease_toward_target();
      end
      v.x = px;
      v.y = py;
      v.moving = pending;
      views_due.push_back(v);
    endfunction

    function void check_result(logic [31:0] x, logic [31:0] y, logic moving);
      cam_view_t v;
      results_seen++;
      if (views_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result x=%h y=%h moving=%b", x, y, moving);
        return;
      end
      v = views_due.pop_front();
      if (v.x !== x || v.y !== y || v.moving !== moving) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected x=%h y=%h moving=%b, got x=%h y=%h moving=%b",
                   v.x, v.y, v.moving, x, y, moving);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         command_i = ecf_pkg::CmdTick;
  logic signed [31:0] coord_x_i = '0;
  logic signed [31:0] coord_y_i = '0;
  logic               centred_i = 1'b0;
  logic               key_up_i = 1'b0;
  logic               key_down_i = 1'b0;
  logic               key_left_i = 1'b0;
  logic               key_right_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] pos_x_o;
  logic signed [31:0] pos_y_o;
  logic               moving_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = ecf_pkg::RegMode;
  logic [15:0]        cfg_data_i = '0;

  camera_scoreboard sb;
  int  items_sent;
  int  stall_cycles;
  bit  sender_calm;
  bit  receiver_calm;
  bit  stimulus_done;

  always #1 clk_i = ~clk_i;

  eased_camera_follow_core uut (.*);

  // Monitor and watchdog share one process so the scoreboard sees each edge in order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        cam_item_t it;
        it.cmd = command_i;
        it.x = coord_x_i;
        it.y = coord_y_i;
        it.centred = centred_i;
        it.up = key_up_i;
        it.down = key_down_i;
        it.left = key_left_i;
        it.right = key_right_i;
        sb.note_item(it);
      end
      if (out_valid_o && out_ready_i) sb.check_result(pos_x_o, pos_y_o, moving_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o) || (sb.views_due.size() == 0 && !in_valid_i))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles > 5000) begin
        $display("Watchdog expired with %0d results outstanding", sb.views_due.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Result side: random back-pressure, with calm stretches where it never stalls.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 99) < 3) receiver_calm = !receiver_calm;
      n = receiver_calm ? 0 : $urandom_range(0, 9);
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_item(cam_item_t it);
    int gap;
    if ($urandom_range(0, 99) < 3) sender_calm = !sender_calm;
    gap = sender_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= it.cmd;
    coord_x_i <= it.x;
    coord_y_i <= it.y;
    centred_i <= it.centred;
    key_up_i <= it.up;
    key_down_i <= it.down;
    key_left_i <= it.left;
    key_right_i <= it.right;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.views_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  function automatic cam_item_t make_item(logic [1:0] cmd, logic [31:0] x, logic [31:0] y,
                                          logic c, logic [3:0] keys);
    cam_item_t it;
    it.cmd = cmd;
    it.x = x;
    it.y = y;
    it.centred = c;
    {it.up, it.down, it.left, it.right} = keys;
    return it;
  endfunction

  // Mostly coordinates a few thousand pixels out so moves settle; some full-range values.
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: return 32'($signed($urandom_range(0, 1023)) - 512);
      default: return 32'($signed($urandom_range(0, 2097151)) - 1048576);
    endcase
  endfunction

  function automatic cam_item_t pick_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return make_item(ecf_pkg::CmdTick, $urandom, $urandom, 1'($urandom_range(0, 1)),
                       4'($urandom));
    else if (r < 67)
      return make_item(ecf_pkg::CmdSet, pick_coord(), pick_coord(), 1'($urandom_range(0, 1)),
                       4'($urandom));
    else if (r < 82)
      return make_item(ecf_pkg::CmdMove, pick_coord(), pick_coord(), 1'($urandom_range(0, 1)),
                       4'($urandom));
    else
      return make_item(ecf_pkg::CmdClick, pick_coord(), pick_coord(),
                       1'($urandom_range(0, 1)), 4'($urandom));
  endfunction

  initial begin
    logic [1:0]  modes[6];
    logic [15:0] widths[6];
    logic [15:0] heights[6];
    modes = '{ecf_pkg::ModeKey, ecf_pkg::ModeMouse, ecf_pkg::ModeMouse, ecf_pkg::ModeOff,
              ecf_pkg::ModeSpare, ecf_pkg::ModeKey};
    widths = '{16'd0, 16'd65535, 16'd641, 16'd1, 16'd100, 16'd640};
    heights = '{16'd0, 16'd65535, 16'd479, 16'd3, 16'd200, 16'd480};
    sb = new();
    sb.clear();
    items_sent = 0;
    stall_cycles = 0;
    stimulus_done = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset view size, first with tracking off, then in key and mouse mode.
    send_item(make_item(ecf_pkg::CmdClick, 32'h100, 32'h100, 1'b0, 4'b0000));
    send_item(make_item(ecf_pkg::CmdTick, '0, '0, 1'b0, 4'b1111));
    send_item(make_item(ecf_pkg::CmdSet, 32'h1000, 32'h2000, 1'b1, 4'b0000));
    send_item(make_item(ecf_pkg::CmdMove, 32'h1080, 32'h2000, 1'b0, 4'b0000));
    send_item(make_item(ecf_pkg::CmdTick, '0, '0, 1'b0, 4'b0000));
    send_item(make_item(ecf_pkg::CmdSet, 32'h80000000, 32'h80000000, 1'b0, 4'b0000));
    send_item(make_item(ecf_pkg::CmdMove, 32'h7fffffff, 32'h7fffffff, 1'b0, 4'b0000));
    repeat (3) send_item(make_item(ecf_pkg::CmdTick, '0, '0, 1'b0, 4'b0000));
    send_item(make_item(ecf_pkg::CmdMove, 32'h00050000, 32'hfffb0000, 1'b1, 4'b0000));
    repeat (3) send_item(make_item(ecf_pkg::CmdTick, '0, '0, 1'b0, 4'b0000));
    drain();
    write_reg(ecf_pkg::RegMode, {14'd0, ecf_pkg::ModeKey});
    send_item(make_item(ecf_pkg::CmdTick, '0, '0, 1'b0, 4'b1000));
    send_item(make_item(ecf_pkg::CmdTick, '0, '0, 1'b0, 4'b0100));
    send_item(make_item(ecf_pkg::CmdTick, '0, '0, 1'b0, 4'b0010));
    send_item(make_item(ecf_pkg::CmdTick, '0, '0, 1'b0, 4'b0001));
    send_item(make_item(ecf_pkg::CmdTick, '0, '0, 1'b0, 4'b1111));
    send_item(make_item(ecf_pkg::CmdClick, 32'h100, 32'h100, 1'b0, 4'b0000));
    drain();
    write_reg(ecf_pkg::RegMode, {14'd0, ecf_pkg::ModeMouse});
    send_item(make_item(ecf_pkg::CmdClick, 32'h7fffffff, 32'h80000000, 1'b0, 4'b0000));
    send_item(make_item(ecf_pkg::CmdClick, 32'h00028000, 32'h0001e000, 1'b1, 4'b0000));
    repeat (2) send_item(make_item(ecf_pkg::CmdTick, '0, '0, 1'b0, 4'b0000));
    drain();

    // Random phases, each under its own register setting.
    for (int p = 0; p < 6; p++) begin
      write_reg(ecf_pkg::RegMode, {14'd0, modes[p]});
      write_reg(ecf_pkg::RegWidth, widths[p]);
      write_reg(ecf_pkg::RegHeight, heights[p]);
      for (int i = 0; i < 330; i++) begin
        // Let the block run dry once mid-phase before continuing.
        if (i == 165) drain();
        send_item(pick_item());
      end
      drain();
    end

    do @(posedge clk_i); while (sb.views_due.size() != 0);
    repeat (300) @(posedge clk_i);
    $display("Sent %0d commands, checked %0d positions over six register settings,",
             items_sent, sb.results_seen);
    $display("covering all tracking modes and view sizes from zero to full scale.");
    if (sb.mismatches == 0 && sb.views_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.views_due.size());
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== eased_camera_follow_core.f =====
+incdir+rtl
rtl/ecf_pkg.sv
rtl/ecf_datapath.sv
rtl/ecf_ctrl.sv
rtl/eased_camera_follow_core.sv
tb/eased_camera_follow_core_tb.sv
